// ----- rtl/tctw_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console tile writer package
// Shared action codes, character codes, bus widths and the control structs
// between the sequencer and the store sweep unit.
// ----------------------------------------------------------------------------
package tctw_pkg;

  typedef enum logic [1:0] {
    ACT_PUT   = 2'd0,
    ACT_SET   = 2'd1,
    ACT_CLEAR = 2'd2,
    ACT_READ  = 2'd3
  } action_e;

  localparam int unsigned InDataW  = 40;
  localparam int unsigned OutDataW = 32;
  localparam int unsigned CharW    = 8;
  localparam int unsigned WordW    = 16;
  localparam int unsigned CurW     = 6;

  localparam logic [CharW-1:0] CharEnd = 8'h00;
  localparam logic [CharW-1:0] CharTab = 8'h09;
  localparam logic [CharW-1:0] CharLf  = 8'h0A;
  localparam logic [CharW-1:0] CharCr  = 8'h0D;
  localparam logic [CharW-1:0] CharSub = 8'h3F;

  typedef struct packed {
    logic start;
    logic copy;
  } sweep_cmd_t;

  typedef struct packed {
    logic rd_en;
    logic wr_en;
    logic wr_zero;
    logic done;
  } sweep_stat_t;

endpackage

// ----- rtl/tctw_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic simple dual-port RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
module tctw_ram #(
  parameter int unsigned Width = 16,
  parameter int unsigned Depth = 1024,
  localparam int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/tctw_sweep.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Store sweep unit
// Walks every map word once: either copies the word one row below into it
// (scroll) or writes zero (clear). Reads run the cycle before their writes.
// ----------------------------------------------------------------------------
module tctw_sweep import tctw_pkg::*; #(
  parameter int unsigned MapWords = 1024,
  parameter int unsigned RowWords = 32,
  localparam int unsigned AddrW = $clog2(MapWords),
  localparam int unsigned CntW  = $clog2(MapWords + 1)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  sweep_cmd_t       cmd_i,
  output sweep_stat_t      stat_o,
  output logic [AddrW-1:0] rd_addr_o,
  output logic [AddrW-1:0] wr_addr_o
);

  logic [CntW-1:0] cnt_q, cnt_d;
  logic            active_q, active_d;
  logic            copy_q, copy_d;
  logic            src_ok_q, src_ok_d;
  logic            last;

  always_comb begin
    last           = active_q && (cnt_q == CntW'(MapWords));
    stat_o.rd_en   = active_q && copy_q && ((32'(cnt_q) + RowWords) < MapWords);
    stat_o.wr_en   = active_q && (cnt_q != '0);
    // past the last source row the copy turns into a clear
    stat_o.wr_zero = !src_ok_q;
    stat_o.done    = last;
    rd_addr_o      = AddrW'(32'(cnt_q) + RowWords);
    wr_addr_o      = AddrW'(cnt_q - CntW'(1));
    src_ok_d       = stat_o.rd_en;

    cnt_d    = cnt_q;
    active_d = active_q;
    copy_d   = copy_q;
    if (cmd_i.start) begin
      cnt_d    = '0;
      active_d = 1'b1;
      copy_d   = cmd_i.copy;
    end else if (active_q) begin
      if (last) begin
        active_d = 1'b0;
      end else begin
        cnt_d = cnt_q + CntW'(1);
      end
    end
  end

  // out of reset, run a clearing pass
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q    <= '0;
      active_q <= 1'b1;
      copy_q   <= 1'b0;
      src_ok_q <= 1'b0;
    end else begin
      cnt_q    <= cnt_d;
      active_q <= active_d;
      copy_q   <= copy_d;
      src_ok_q <= src_ok_d;
    end
  end

endmodule

// ----- rtl/text_console_tile_writer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console tile writer
// Prints byte-wide character codes into a packed tile map with cursor
// tracking, line wrap and scroll; also sets the cursor, clears and reads.
// ----------------------------------------------------------------------------
//  channel   dir  handshake                    content
//  s_axis    in   s_axis_tvalid/s_axis_tready  action, char, cursor set, address
//  m_axis    out  m_axis_tvalid/m_axis_tready  map word, cursor row and column
//  cfg       in   cfg_we_i                     print enable
//
//  Stored character: map word read, then merged write.
//  Newline, tab, skipped byte, set cursor, disabled put: no map access.
//  Read word: a map word read. Clear: a sweep that zeroes every map word;
//  a scroll adds a copying sweep to a put, both over the single-word map port.
//  After reset a clearing pass runs with tready low.
//  A finished item waits in the output register; one more item may be taken
//  and its result then holds until the register frees.
// ----------------------------------------------------------------------------
module text_console_tile_writer import tctw_pkg::*; #(
  parameter int unsigned TEXT_ROWS    = 32,
  parameter int unsigned TEXT_COLUMNS = 42,
  parameter int unsigned ROW_BYTES    = 64,
  parameter int unsigned TAB_STEP     = 3
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                cfg_we_i,
  input  logic                cfg_wdata_i,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  // [7:0] char_byte, [15:8] set_column, [23:16] set_row, [33:24] word_address
  input  logic [InDataW-1:0]  s_axis_tdata,
  // [1:0] action
  input  logic [1:0]          s_axis_tuser,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  // [15:0] map_word, [21:16] cursor_row, [27:22] cursor_column
  output logic [OutDataW-1:0] m_axis_tdata
);

  localparam int unsigned RowWords = ROW_BYTES / 2;
  localparam int unsigned MapWords = TEXT_ROWS * RowWords;
  localparam int unsigned AddrW    = $clog2(MapWords);
  localparam int unsigned RowW     = $clog2(TEXT_ROWS + 1);
  localparam int unsigned ColW     = $clog2(TEXT_COLUMNS + TAB_STEP);

  typedef enum logic [7:0] {
    ST_INIT   = 8'b0000_0001,
    ST_IDLE   = 8'b0000_0010,
    ST_SCROLL = 8'b0000_0100,
    ST_CLEAR  = 8'b0000_1000,
    ST_CHAR   = 8'b0001_0000,
    ST_WRITE  = 8'b0010_0000,
    ST_READ   = 8'b0100_0000,
    ST_RESP   = 8'b1000_0000
  } state_e;

  state_e           state_q, state_d;
  logic [RowW-1:0]  row_q, row_d;
  logic [ColW-1:0]  col_q, col_d;
  logic             skip_q, skip_d;
  logic             en_q;
  logic [CharW-1:0] code_q, code_d;
  logic [AddrW-1:0] waddr_q, waddr_d;
  logic [WordW-1:0] word_q, word_d;
  logic             out_valid_q, out_valid_d;
  logic [WordW-1:0] out_word_q, out_word_d;
  logic [CurW-1:0]  out_row_q, out_row_d;
  logic [CurW-1:0]  out_col_q, out_col_d;

  logic [CharW-1:0] in_byte, in_set_col, in_set_row, in_char;
  logic [9:0]       in_waddr;
  action_e          in_action;

  logic             wrap_col, need_scroll;
  logic [RowW:0]    row_nx;
  logic [RowW-1:0]  row_wr;
  logic [ColW-1:0]  col_nx;

  logic [CharW-1:0] step_code;
  logic [RowW-1:0]  step_row;
  logic [ColW-1:0]  step_col;
  logic [ColW-2:0]  step_half;
  logic             step_in_row, step_newline, step_tab;
  logic [AddrW-1:0] step_addr;

  logic             do_char, do_finish;
  logic             top_re, top_we;
  logic [AddrW-1:0] top_raddr;
  logic [WordW-1:0] top_wdata;

  sweep_cmd_t       sweep_cmd;
  sweep_stat_t      sweep_stat;
  logic [AddrW-1:0] sw_rd_addr, sw_wr_addr;
  logic             sweep_busy;

  logic             ram_we, ram_re;
  logic [AddrW-1:0] ram_waddr, ram_raddr;
  logic [WordW-1:0] ram_wdata, ram_rdata;

  assign in_byte    = s_axis_tdata[7:0];
  assign in_set_col = s_axis_tdata[15:8];
  assign in_set_row = s_axis_tdata[23:16];
  assign in_waddr   = s_axis_tdata[33:24];
  assign in_action  = action_e'(s_axis_tuser);
  assign in_char    = in_byte[7] ? CharSub : in_byte;

  // wrap ahead of a printed code
  always_comb begin
    wrap_col    = 32'(col_q) >= TEXT_COLUMNS;
    row_nx      = wrap_col ? ({1'b0, row_q} + (RowW+1)'(1)) : {1'b0, row_q};
    col_nx      = wrap_col ? '0 : col_q;
    need_scroll = 32'(row_nx) >= TEXT_ROWS;
    row_wr      = need_scroll ? RowW'(TEXT_ROWS - 1) : RowW'(row_nx);
  end

  always_comb begin
    step_code    = (state_q == ST_CHAR) ? code_q : in_char;
    step_row     = (state_q == ST_CHAR) ? row_q : row_wr;
    step_col     = (state_q == ST_CHAR) ? col_q : col_nx;
    step_half    = step_col[ColW-1:1];
    step_in_row  = 32'(step_half) < RowWords;
    step_addr    = AddrW'(32'(step_row) * RowWords + 32'(step_half));
    step_newline = (step_code >= CharLf) && (step_code <= CharCr);
    step_tab     = step_code == CharTab;
  end

  assign top_wdata = col_q[0] ? {code_q, ram_rdata[7:0]} : {ram_rdata[15:8], code_q};

  always_comb begin
    state_d     = state_q;
    row_d       = row_q;
    col_d       = col_q;
    skip_d      = skip_q;
    code_d      = code_q;
    waddr_d     = waddr_q;
    word_d      = word_q;
    top_re      = 1'b0;
    top_we      = 1'b0;
    top_raddr   = step_addr;
    sweep_cmd   = '0;
    do_char     = 1'b0;
    do_finish   = 1'b0;
    out_valid_d = out_valid_q && !m_axis_tready;
    out_word_d  = out_word_q;
    out_row_d   = out_row_q;
    out_col_d   = out_col_q;

    unique case (state_q)
      ST_INIT: begin
        if (sweep_stat.done) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (s_axis_tvalid) begin
          word_d = '0;
          unique case (in_action)
            ACT_PUT: begin
              if (!en_q) begin
                do_finish = 1'b1;
              end else if (in_byte == CharEnd || skip_q) begin
                skip_d    = 1'b0;
                do_finish = 1'b1;
              end else begin
                skip_d = in_byte[7];
                code_d = in_char;
                if (need_scroll) begin
                  row_d          = row_wr;
                  col_d          = col_nx;
                  sweep_cmd.start = 1'b1;
                  sweep_cmd.copy  = 1'b1;
                  state_d        = ST_SCROLL;
                end else begin
                  do_char = 1'b1;
                end
              end
            end
            ACT_SET: begin
              row_d = (32'(in_set_row) < TEXT_ROWS) ? RowW'(in_set_row)
                                                    : RowW'(TEXT_ROWS - 1);
              col_d = (32'(in_set_col) < TEXT_COLUMNS) ? ColW'(in_set_col)
                                                       : ColW'(TEXT_COLUMNS - 1);
              skip_d    = 1'b0;
              do_finish = 1'b1;
            end
            ACT_CLEAR: begin
              row_d           = '0;
              col_d           = '0;
              skip_d          = 1'b0;
              sweep_cmd.start = 1'b1;
              state_d         = ST_CLEAR;
            end
            ACT_READ: begin
              if (32'(in_waddr) < MapWords) begin
                top_re    = 1'b1;
                top_raddr = AddrW'(in_waddr);
                state_d   = ST_READ;
              end else begin
                do_finish = 1'b1;
              end
            end
          endcase
        end
      end
      ST_SCROLL: begin
        if (sweep_stat.done) begin
          state_d = ST_CHAR;
        end
      end
      ST_CLEAR: begin
        if (sweep_stat.done) begin
          do_finish = 1'b1;
        end
      end
      ST_CHAR: begin
        do_char = 1'b1;
      end
      ST_WRITE: begin
        top_we    = 1'b1;
        col_d     = col_q + ColW'(1);
        do_finish = 1'b1;
      end
      ST_READ: begin
        word_d    = ram_rdata;
        do_finish = 1'b1;
      end
      ST_RESP: begin
        do_finish = 1'b1;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase

    if (do_char) begin
      row_d = step_row;
      col_d = step_col;
      if (step_newline) begin
        row_d     = step_row + RowW'(1);
        col_d     = '0;
        do_finish = 1'b1;
      end else if (step_tab) begin
        col_d     = ColW'(32'(step_col) + TAB_STEP);
        do_finish = 1'b1;
      end else if (step_in_row) begin
        // fetch the word now, merge and write it next cycle
        top_re    = 1'b1;
        top_raddr = step_addr;
        waddr_d   = step_addr;
        code_d    = step_code;
        state_d   = ST_WRITE;
      end else begin
        col_d     = step_col + ColW'(1);
        do_finish = 1'b1;
      end
    end

    if (do_finish) begin
      if (!out_valid_q || m_axis_tready) begin
        out_valid_d = 1'b1;
        out_word_d  = word_d;
        out_row_d   = CurW'(row_d);
        out_col_d   = CurW'(col_d);
        state_d     = ST_IDLE;
      end else begin
        state_d = ST_RESP;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_INIT;
      row_q       <= RowW'(TEXT_ROWS - 1);
      col_q       <= '0;
      skip_q      <= 1'b0;
      en_q        <= 1'b1;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      row_q       <= row_d;
      col_q       <= col_d;
      skip_q      <= skip_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        en_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    code_q     <= code_d;
    waddr_q    <= waddr_d;
    word_q     <= word_d;
    out_word_q <= out_word_d;
    out_row_q  <= out_row_d;
    out_col_q  <= out_col_d;
  end

  tctw_sweep #(
    .MapWords (MapWords),
    .RowWords (RowWords)
  ) u_sweep (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (sweep_cmd),
    .stat_o    (sweep_stat),
    .rd_addr_o (sw_rd_addr),
    .wr_addr_o (sw_wr_addr)
  );

  assign sweep_busy = (state_q == ST_INIT) || (state_q == ST_SCROLL) ||
                      (state_q == ST_CLEAR);

  always_comb begin
    if (sweep_busy) begin
      ram_we    = sweep_stat.wr_en;
      ram_waddr = sw_wr_addr;
      ram_wdata = sweep_stat.wr_zero ? '0 : ram_rdata;
      ram_re    = sweep_stat.rd_en;
      ram_raddr = sw_rd_addr;
    end else begin
      ram_we    = top_we;
      ram_waddr = waddr_q;
      ram_wdata = top_wdata;
      ram_re    = top_re;
      ram_raddr = top_raddr;
    end
  end

  tctw_ram #(
    .Width (WordW),
    .Depth (MapWords)
  ) u_map (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  assign s_axis_tready = state_q == ST_IDLE;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {4'h0, out_col_q, out_row_q, out_word_q};

endmodule

// ----- rtl/tctw_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Text console tile writer port checker
// Watches the stream ports for ordering, reset and cursor range.
// ----------------------------------------------------------------------------
module tctw_checker import tctw_pkg::*; #(
  parameter int unsigned TEXT_ROWS    = 32,
  parameter int unsigned TEXT_COLUMNS = 42,
  parameter int unsigned TAB_STEP     = 3
) (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                s_axis_tvalid,
  input logic                s_axis_tready,
  input logic                m_axis_tvalid,
  input logic                m_axis_tready,
  input logic [OutDataW-1:0] m_axis_tdata
);

  logic [1:0] pend_q;
  logic       in_acc, out_acc;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;

  // items taken but not yet delivered
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else if (in_acc && !out_acc) begin
      pend_q <= pend_q + 2'd1;
    end else if (out_acc && !in_acc) begin
      pend_q <= pend_q - 2'd1;
    end
  end

  a_out_hold : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  a_reset_quiet : assert property (@(posedge clk_i)
    !rst_ni |-> !s_axis_tready && !m_axis_tvalid)
    else $error("handshake active during reset");

  a_pending : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (pend_q <= 2'd2) && (!m_axis_tvalid || pend_q != 2'd0))
    else $error("result count out of step with taken items");

  a_cursor_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (32'(m_axis_tdata[21:16]) <= TEXT_ROWS) &&
                      (32'(m_axis_tdata[27:22]) <= TEXT_COLUMNS + TAB_STEP - 1))
    else $error("cursor outside its range");

endmodule

bind text_console_tile_writer tctw_checker #(
  .TEXT_ROWS    (TEXT_ROWS),
  .TEXT_COLUMNS (TEXT_COLUMNS),
  .TAB_STEP     (TAB_STEP)
) u_tctw_checker (.*);
